### hdl/wmt_pkg.sv
// shared types and codes for the worker membership table
package wmt_pkg;
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    HL_ONLINE   = 2'd0,
    HL_DRAINING = 2'd1,
    HL_OFFLINE  = 2'd2,
    HL_OTHER    = 2'd3
  } health_t;

  localparam logic MODE_REGISTER  = 1'b0;
  localparam logic MODE_HEARTBEAT = 1'b1;

  // command broadcast to every cell
  typedef struct packed {
    logic        req;
    logic        mode;
    logic [31:0] key;
    logic [1:0]  health;
    logic [47:0] stamp;
    logic [47:0] mem_total;
    logic [47:0] mem_reserved;
    logic [15:0] cores_total;
    logic [15:0] cores_reserved;
  } cmd_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    logic        hit;
    logic        revive;
    logic [47:0] mem_total;
    logic [47:0] mem_reserved;
    logic [15:0] cores_total;
    logic [15:0] cores_reserved;
  } chain_t;
endpackage

### hdl/wmt_cell.sv
// one table slot: key compare, entry storage and hit forwarding along the row
module wmt_cell (
  input  logic            clk,
  input  wmt_pkg::cmd_t   cmd,
  input  logic            slot_used,
  input  logic            wr_here,
  input  logic            commit,
  input  wmt_pkg::chain_t chain_in,
  output wmt_pkg::chain_t chain_out
);
  import wmt_pkg::*;

  logic [31:0] key_r;
  logic [1:0]  health_r;
  logic [47:0] seen_r;
  logic [47:0] mem_total_r;
  logic [47:0] mem_reserved_r;
  logic [15:0] cores_total_r;
  logic [15:0] cores_reserved_r;
  logic        match;

  assign match = slot_used && (key_r == cmd.key);

  // pass the first hit down the row, with this slot's data if it is the one
  always_comb begin
    chain_out = chain_in;
    if (!chain_in.hit && match) begin
      chain_out.hit            = 1'b1;
      chain_out.revive         = (health_r == HL_OFFLINE);
      chain_out.mem_total      = mem_total_r;
      chain_out.mem_reserved   = mem_reserved_r;
      chain_out.cores_total    = cores_total_r;
      chain_out.cores_reserved = cores_reserved_r;
    end
  end

  // entry update on registration or heartbeat
  always_ff @(posedge clk) begin
    if (commit && wr_here) begin
      key_r            <= cmd.key;
      health_r         <= cmd.health;
      seen_r           <= cmd.stamp;
      mem_total_r      <= cmd.mem_total;
      mem_reserved_r   <= cmd.mem_reserved;
      cores_total_r    <= cmd.cores_total;
      cores_reserved_r <= cmd.cores_reserved;
    end else if (commit && cmd.mode == MODE_HEARTBEAT && match && !chain_in.hit) begin
      seen_r <= cmd.stamp;
      if (health_r == HL_OFFLINE) health_r <= HL_ONLINE;
    end
  end
endmodule

### hdl/wmt_ctrl.sv
// fill count, running sums, generation and result register
module wmt_ctrl #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  wmt_pkg::cmd_t   cmd,
  input  wmt_pkg::chain_t chain_end,
  output logic [$clog2(MAX_ENTRIES+1)-1:0] fill,
  output logic            commit,
  output logic            out_valid,
  output logic [1:0]      out_status_code,
  output logic [52:0]     out_sum_mem_total,
  output logic [52:0]     out_sum_mem_reserved,
  output logic [20:0]     out_sum_cores_total,
  output logic [20:0]     out_sum_cores_reserved,
  output logic [5:0]      out_live_count,
  output logic            out_cluster_mode,
  output logic [31:0]     out_generation
);
  import wmt_pkg::*;
  localparam int FW = $clog2(MAX_ENTRIES+1);

  logic [FW-1:0] fill_r;
  logic          oper_r;
  logic [31:0]   gen_r;
  logic [52:0]   mt_r, mr_r;
  logic [20:0]   ct_r, cr_r;
  logic [5:0]    live_r;
  logic          valid_r;
  logic [1:0]    stat_r;
  status_t       status;
  logic          add;
  logic [47:0]   a_mt, a_mr;
  logic [15:0]   a_ct, a_cr;

  assign fill = fill_r;

  // decide outcome
  always_comb begin
    status = ST_OK;
    add  = 1'b0;
    a_mt = cmd.mem_total;
    a_mr = cmd.mem_reserved;
    a_ct = cmd.cores_total;
    a_cr = cmd.cores_reserved;
    if (cmd.mode == MODE_REGISTER) begin
      if (fill_r == FW'(MAX_ENTRIES)) status = ST_FULL;
      else if (chain_end.hit) status = ST_DUPLICATE;
      else add = (cmd.health == HL_ONLINE) || (cmd.health == HL_DRAINING);
    end else begin
      if (!chain_end.hit) status = ST_NOT_FOUND;
      else add = chain_end.revive;
      a_mt = chain_end.mem_total;
      a_mr = chain_end.mem_reserved;
      a_ct = chain_end.cores_total;
      a_cr = chain_end.cores_reserved;
    end
  end

  assign commit = cmd.req && (status == ST_OK);

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0; oper_r <= 1'b0; gen_r <= 32'd1;
      mt_r <= '0; mr_r <= '0; ct_r <= '0; cr_r <= '0; live_r <= '0;
      valid_r <= 1'b0; stat_r <= ST_OK;
    end else begin
      valid_r <= cmd.req;
      if (cmd.req) stat_r <= status;
      if (commit) begin
        gen_r <= gen_r + 32'd1;
        if (cmd.mode == MODE_REGISTER) begin
          fill_r <= fill_r + FW'(1);
          oper_r <= 1'b1;
        end
        if (add) begin
          mt_r   <= mt_r + {5'd0, a_mt};
          mr_r   <= mr_r + {5'd0, a_mr};
          ct_r   <= ct_r + {5'd0, a_ct};
          cr_r   <= cr_r + {5'd0, a_cr};
          live_r <= live_r + 6'd1;
        end
      end
    end
  end

  assign out_valid              = valid_r;
  assign out_status_code        = stat_r;
  assign out_sum_mem_total      = mt_r;
  assign out_sum_mem_reserved   = mr_r;
  assign out_sum_cores_total    = ct_r;
  assign out_sum_cores_reserved = cr_r;
  assign out_live_count         = live_r;
  assign out_cluster_mode       = oper_r;
  assign out_generation         = gen_r;
endmodule

### hdl/worker_membership_table.sv
// top level of the worker membership table
// Usage:
//   Pulse start with the in_ fields while busy is low; the item is taken at
//   that edge. busy is always low, so one item can be issued every cycle.
//   Each item gives one result: out_valid is high for exactly one cycle,
//   in the cycle after the item is taken, with out_status_code and the sums,
//   live count, cluster mode and generation as they stand after the item.
//   Throughput 1 item per cycle: the key lookup runs along
//   a row of MAX_ENTRIES slot cells, each comparing its stored key and passing
//   the first hit and its entry data to its neighbor, all in the take cycle.
//   The receiver cannot stall; results are never held.
//   Synchronous reset empties the table (fill count zero), clears the sums,
//   sets generation to one and cluster mode to bootstrap; no clearing pass.
module worker_membership_table #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [31:0] in_worker_key,
  input  logic [1:0]  in_health_in,
  input  logic [47:0] in_time_stamp,
  input  logic [47:0] in_mem_total_in,
  input  logic [47:0] in_mem_reserved_in,
  input  logic [15:0] in_cores_total_in,
  input  logic [15:0] in_cores_reserved_in,
  output logic        out_valid,
  output logic [1:0]  out_status_code,
  output logic [52:0] out_sum_mem_total,
  output logic [52:0] out_sum_mem_reserved,
  output logic [20:0] out_sum_cores_total,
  output logic [20:0] out_sum_cores_reserved,
  output logic [5:0]  out_live_count,
  output logic        out_cluster_mode,
  output logic [31:0] out_generation
);
  import wmt_pkg::*;
  localparam int FW = $clog2(MAX_ENTRIES+1);

  cmd_t          cmd;
  chain_t        chain [MAX_ENTRIES+1];
  logic [FW-1:0] fill;
  logic          commit;

  assign busy = 1'b0;

  // command bundle
  always_comb begin
    cmd.req            = start;
    cmd.mode           = in_mode;
    cmd.key            = in_worker_key;
    cmd.health         = in_health_in;
    cmd.stamp          = in_time_stamp;
    cmd.mem_total      = in_mem_total_in;
    cmd.mem_reserved   = in_mem_reserved_in;
    cmd.cores_total    = in_cores_total_in;
    cmd.cores_reserved = in_cores_reserved_in;
  end

  assign chain[0] = '0;

  // row of slot cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    wmt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .slot_used (FW'(i) < fill),
      .wr_here   ((cmd.mode == MODE_REGISTER) && (fill == FW'(i))),
      .commit    (commit),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  wmt_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .chain_end              (chain[MAX_ENTRIES]),
    .fill                   (fill),
    .commit                 (commit),
    .out_valid              (out_valid),
    .out_status_code        (out_status_code),
    .out_sum_mem_total      (out_sum_mem_total),
    .out_sum_mem_reserved   (out_sum_mem_reserved),
    .out_sum_cores_total    (out_sum_cores_total),
    .out_sum_cores_reserved (out_sum_cores_reserved),
    .out_live_count         (out_live_count),
    .out_cluster_mode       (out_cluster_mode),
    .out_generation         (out_generation)
  );
endmodule

### hdl/wmt_checker.sv
// port-level checks for the worker membership table
module wmt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status_code,
  input logic [5:0]  out_live_count,
  input logic        out_cluster_mode,
  input logic [31:0] out_generation
);
  import wmt_pkg::*;

  // one result for each item, in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid) else $error("missing result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid) else $error("result without item");

  // operational once set stays set
  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cluster_mode) |=> out_cluster_mode) else $error("mode fell");

  // refused item leaves generation unchanged between results
  a_gen_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid) && out_status_code != ST_OK)
      |-> out_generation == $past(out_generation)) else $error("generation moved");

  // live count never drops
  a_live_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(rst_n) |-> out_live_count >= $past(out_live_count))
    else $error("live count dropped");
endmodule

bind worker_membership_table wmt_checker u_wmt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status_code  (out_status_code),
  .out_live_count   (out_live_count),
  .out_cluster_mode (out_cluster_mode),
  .out_generation   (out_generation)
);

### bench/worker_membership_table_test.sv
// testbench for the worker membership table: directed and random items checked against a predictor
`timescale 1ns / 1ps
module worker_membership_table_test;
  import wmt_pkg::*;

  localparam int SLOTS = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [52:0] mem_total;
    logic [52:0] mem_reserved;
    logic [20:0] cores_total;
    logic [20:0] cores_reserved;
    logic [5:0]  live;
    logic        cmode;
    logic [31:0] gen;
  } summary_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [31:0] in_worker_key = '0;
  logic [1:0] in_health_in = '0;
  logic [47:0] in_time_stamp = '0;
  logic [47:0] in_mem_total_in = '0;
  logic [47:0] in_mem_reserved_in = '0;
  logic [15:0] in_cores_total_in = '0;
  logic [15:0] in_cores_reserved_in = '0;
  logic out_valid;
  logic [1:0] out_status_code;
  logic [52:0] out_sum_mem_total, out_sum_mem_reserved;
  logic [20:0] out_sum_cores_total, out_sum_cores_reserved;
  logic [5:0] out_live_count;
  logic out_cluster_mode;
  logic [31:0] out_generation;

  worker_membership_table dut (.*);

  always #5 clk = ~clk;

  // predictor copy of the table
  logic [31:0] tk_key [SLOTS];
  logic [1:0]  tk_health [SLOTS];
  logic [47:0] tk_mem_t [SLOTS], tk_mem_r [SLOTS];
  logic [15:0] tk_cor_t [SLOTS], tk_cor_r [SLOTS];
  int          tk_filled;
  logic        tk_oper;
  logic [31:0] tk_gen;
  logic [52:0] tk_sum_mt, tk_sum_mr;
  logic [20:0] tk_sum_ct, tk_sum_cr;
  logic [5:0]  tk_live;

  summary_t expected_summaries[$];
  int errors = 0;
  int bursting = 0;

  function automatic int lookup_slot(logic [31:0] key);
    for (int i = 0; i < tk_filled; i++)
      if (tk_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void count_live(int s);
    tk_sum_mt += 53'(tk_mem_t[s]);
    tk_sum_mr += 53'(tk_mem_r[s]);
    tk_sum_ct += 21'(tk_cor_t[s]);
    tk_sum_cr += 21'(tk_cor_r[s]);
    tk_live += 6'd1;
  endfunction

  function automatic summary_t apply_item(logic mode, logic [31:0] key, logic [1:0] health,
      logic [47:0] mt, logic [47:0] mr, logic [15:0] ct, logic [15:0] cr);
    summary_t r;
    int s;
    r.status = ST_OK;
    if (mode == MODE_REGISTER) begin
      if (tk_filled >= SLOTS) r.status = ST_FULL;
      else if (lookup_slot(key) >= 0) r.status = ST_DUPLICATE;
      else begin
        s = tk_filled;
        tk_key[s] = key; tk_health[s] = health;
        tk_mem_t[s] = mt; tk_mem_r[s] = mr; tk_cor_t[s] = ct; tk_cor_r[s] = cr;
        tk_filled++;
        if (health == HL_ONLINE || health == HL_DRAINING) count_live(s);
        tk_oper = 1'b1;
        tk_gen += 32'd1;
      end
    end else begin
      s = lookup_slot(key);
      if (s < 0) r.status = ST_NOT_FOUND;
      else begin
        if (tk_health[s] == HL_OFFLINE) begin
          tk_health[s] = HL_ONLINE;
          count_live(s);
        end
        tk_gen += 32'd1;
      end
    end
    r.mem_total = tk_sum_mt; r.mem_reserved = tk_sum_mr;
    r.cores_total = tk_sum_ct; r.cores_reserved = tk_sum_cr;
    r.live = tk_live; r.cmode = tk_oper; r.gen = tk_gen;
    return r;
  endfunction

  // random gap between bursts
  task automatic pace();
    if (bursting == 0) begin
      bursting = $urandom_range(1, 30);
      if ($urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 6)) begin
          @(posedge clk);
          start <= 1'b0;
        end
    end
    bursting--;
  endtask

  task automatic send_item(logic mode, logic [31:0] key, logic [1:0] health, logic [47:0] ts,
      logic [47:0] mt, logic [47:0] mr, logic [15:0] ct, logic [15:0] cr);
    pace();
    @(posedge clk);
    start <= 1'b1; in_mode <= mode; in_worker_key <= key; in_health_in <= health;
    in_time_stamp <= ts; in_mem_total_in <= mt; in_mem_reserved_in <= mr;
    in_cores_total_in <= ct; in_cores_reserved_in <= cr;
    expected_summaries.push_back(apply_item(mode, key, health, mt, mr, ct, cr));
    do @(posedge clk); while (busy);
    // item taken at this edge; drop start
    start <= 1'b0;
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  task automatic send_random(logic mode, logic [31:0] key);
    send_item(mode, key, 2'($urandom_range(0, 3)), rand48(), rand48(), rand48(),
              16'($urandom()), 16'($urandom()));
  endtask

  task automatic wait_drained();
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    summary_t e;
    if (rst_n && out_valid) begin
      if (expected_summaries.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = expected_summaries.pop_front();
        if (out_status_code !== e.status) begin
          $error("status_code exp %0d got %0d", e.status, out_status_code); errors++; end
        if (out_sum_mem_total !== e.mem_total) begin
          $error("sum_mem_total exp %0d got %0d", e.mem_total, out_sum_mem_total); errors++; end
        if (out_sum_mem_reserved !== e.mem_reserved) begin
          $error("sum_mem_reserved exp %0d got %0d", e.mem_reserved, out_sum_mem_reserved);
          errors++; end
        if (out_sum_cores_total !== e.cores_total) begin
          $error("sum_cores_total exp %0d got %0d", e.cores_total, out_sum_cores_total);
          errors++; end
        if (out_sum_cores_reserved !== e.cores_reserved) begin
          $error("sum_cores_reserved exp %0d got %0d", e.cores_reserved,
                 out_sum_cores_reserved); errors++; end
        if (out_live_count !== e.live) begin
          $error("live_count exp %0d got %0d", e.live, out_live_count); errors++; end
        if (out_cluster_mode !== e.cmode) begin
          $error("cluster_mode exp %0d got %0d", e.cmode, out_cluster_mode); errors++; end
        if (out_generation !== e.gen) begin
          $error("generation exp %0d got %0d", e.gen, out_generation); errors++; end
      end
    end
  end

  // directed extremes, health codes and refusals
  task automatic test_directed();
    logic [47:0] ones48 = '1;
    send_item(MODE_HEARTBEAT, 32'hFFFF_FFFF, HL_ONLINE, '0, '0, '0, '0, '0);
    send_item(MODE_REGISTER, 32'd0, HL_ONLINE, ones48, ones48, ones48, 16'hFFFF, 16'hFFFF);
    send_item(MODE_REGISTER, 32'd0, HL_DRAINING, '0, '0, '0, '0, '0);
    send_item(MODE_REGISTER, 32'hFFFF_FFFF, HL_DRAINING, '0, ones48, '0, 16'hFFFF, '0);
    send_item(MODE_REGISTER, 32'h1234_5678, HL_OFFLINE, '0, 48'd77, 48'd7, 16'd5, 16'd1);
    send_item(MODE_REGISTER, 32'hA5A5_A5A5, HL_OTHER, '0, ones48, ones48, 16'd9, 16'd9);
    send_item(MODE_HEARTBEAT, 32'h1234_5678, HL_OTHER, ones48, ones48, '0, '1, '1);
    send_item(MODE_HEARTBEAT, 32'h1234_5678, HL_OFFLINE, '0, '0, '0, '0, '0);
    send_item(MODE_HEARTBEAT, 32'hA5A5_A5A5, HL_ONLINE, ones48, '0, '0, '0, '0);
    send_item(MODE_HEARTBEAT, 32'd0, HL_ONLINE, '0, '0, '0, '0, '0);
    send_item(MODE_HEARTBEAT, 32'hFFFF_FFFF, HL_ONLINE, '0, '0, '0, '0, '0);
    send_item(MODE_HEARTBEAT, 32'h5555_5555, HL_ONLINE, '0, '0, '0, '0, '0);
  endtask

  // fill to capacity with max resources, then probe full
  task automatic test_fill();
    logic [47:0] ones48 = '1;
    for (int i = 0; tk_filled < SLOTS; i++)
      send_item(MODE_REGISTER, 32'h8000_0000 + i, HL_ONLINE, rand48(), ones48, ones48,
                16'hFFFF, 16'hFFFF);
    send_item(MODE_REGISTER, 32'h7777_7777, HL_ONLINE, '0, '0, '0, '0, '0);
    send_item(MODE_REGISTER, 32'd0, HL_ONLINE, '0, '0, '0, '0, '0);
    send_item(MODE_HEARTBEAT, 32'h8000_0003, HL_ONLINE, '0, '0, '0, '0, '0);
  endtask

  // random traffic mostly on keys already in the table
  task automatic test_random(int n);
    int s;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) send_random(1'($urandom_range(0, 1)), $urandom());
      else begin
        s = $urandom_range(0, tk_filled - 1);
        send_random(1'($urandom_range(0, 1)), tk_key[s]);
      end
    end
  endtask

  initial begin
    tk_filled = 0; tk_oper = 1'b0; tk_gen = 32'd1;
    tk_sum_mt = '0; tk_sum_mr = '0; tk_sum_ct = '0; tk_sum_cr = '0; tk_live = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(300);
    wait_drained();
    test_fill();
    test_random(1500);
    wait_drained();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
